>>> rtl/core/nearest_palette_color_macros.svh
// Assertion macros shared by the palette quantizer RTL.
`ifndef NEAREST_PALETTE_COLOR_MACROS_SVH
`define NEAREST_PALETTE_COLOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define NPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/npc_pkg.sv
// Package: types and constants of the nearest palette color quantizer.
package npc_pkg;

   // Channel and palette geometry
   localparam int CHAN_W                  = 8;
   localparam int ENTRY_W                 = 3 * CHAN_W;
   localparam int INDEX_W                 = 8;
   localparam int DEFAULT_PALETTE_ENTRIES = 256;

   // Largest squared distance is 3*255*255, which fits in 18 bits
   localparam int DIST_W = 18;
   // Start value above any real distance, so the first entry always wins
   localparam logic [DIST_W-1:0] DIST_START = '1;

   // Request type codes
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_PIXEL = 1'b1;

   // Search sequencer states
   typedef enum logic [1:0] {
      NPC_IDLE,
      NPC_SCAN,
      NPC_DRAIN,
      NPC_FINISH
   } npc_state_type;

endpackage

>>> rtl/core/npc_req_if.sv
// Interface: request channel (palette loads and pixels).
interface npc_req_if
   import npc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [INDEX_W-1:0] entry_index;
   logic [CHAN_W-1:0]  red;
   logic [CHAN_W-1:0]  green;
   logic [CHAN_W-1:0]  blue;

   modport source (output valid, req_type, entry_index, red, green, blue, input ready);
   modport sink   (input valid, req_type, entry_index, red, green, blue, output ready);
endinterface

>>> rtl/core/npc_rsp_if.sv
// Interface: response channel (nearest palette index).
interface npc_rsp_if
   import npc_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] color_index;

   modport source (output valid, color_index, input ready);
   modport sink   (input valid, color_index, output ready);
endinterface

>>> rtl/core/nearest_palette_color.sv
// Top level: nearest palette color quantizer with on-chip palette memory.
//
// Load requests (req_type 0) write one palette entry; an entry_index at or
// beyond PALETTE_ENTRIES is dropped. A pixel request (req_type 1) scans
// entries 1..PALETTE_ENTRIES-1 and returns the index of least squared RGB
// distance, lowest index on a tie; entry 0 is never chosen. The palette sits
// in one single-port-read memory read one entry per cycle, so a pixel holds
// the block through the reads of entries 1..PALETTE_ENTRIES-1, the drain of
// the two pipeline stages and the posting of the result, plus, in the posting
// step, any wait for the previous result's transfer. Requests are taken only
// while no pixel is in the search and reset is low; a result waiting on
// rsp_chan does not block loads or the next pixel's search. Every entry a
// pixel search reads must have been loaded since reset; the memory is not
// cleared.
`include "nearest_palette_color_macros.svh"

module nearest_palette_color
   import npc_pkg::*;
#(
   parameter int PALETTE_ENTRIES = DEFAULT_PALETTE_ENTRIES
) (
   input  logic     clock,
   input  logic     reset,
   npc_req_if.sink   req_chan,
   npc_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(PALETTE_ENTRIES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);

   npc_state_type state_ff, state_in;

   logic [ENTRY_W-1:0] palette_mem [PALETTE_ENTRIES];

   logic [CHAN_W-1:0]  pix_r_ff, pix_g_ff, pix_b_ff;
   logic [AW-1:0]      scan_addr_ff;
   logic               issue;

   logic               s1_vld_ff, s1_last_ff;
   logic [AW-1:0]      s1_idx_ff;
   logic [ENTRY_W-1:0] rd_data_ff;

   logic               s2_vld_ff, s2_last_ff;
   logic [AW-1:0]      s2_idx_ff;
   logic [DIST_W-1:0]  dist_ff;

   logic [DIST_W-1:0]  best_dist_ff;
   logic [AW-1:0]      best_idx_ff;

   logic               rsp_valid_ff;
   logic [INDEX_W-1:0] color_ff;

   logic               req_xfer, load_xfer, pixel_xfer, load_in_range;
   logic               rsp_free, post_result;
   logic [CHAN_W-1:0]  diff_r, diff_g, diff_b;
   logic [2*CHAN_W-1:0] sq_r, sq_g, sq_b;
   logic [DIST_W-1:0]  dist_sum;

   // Handshake decode
   assign req_chan.ready = (state_ff == NPC_IDLE) && !reset;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign load_in_range  = ({1'b0, req_chan.entry_index} < (INDEX_W + 1)'(PALETTE_ENTRIES));
   assign load_xfer      = req_xfer && (req_chan.req_type == REQ_LOAD) && load_in_range;
   assign pixel_xfer     = req_xfer && (req_chan.req_type == REQ_PIXEL);
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign issue          = (state_ff == NPC_SCAN);

   // Sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= NPC_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencer next state
   always_comb begin
      state_in    = state_ff;
      post_result = 1'b0;
      unique case (state_ff)
         NPC_IDLE: begin
            if (pixel_xfer) state_in = NPC_SCAN;
         end
         NPC_SCAN: begin
            if (scan_addr_ff == LAST_ADDR) state_in = NPC_DRAIN;
         end
         NPC_DRAIN: begin
            if (s2_vld_ff && s2_last_ff) state_in = NPC_FINISH;
         end
         NPC_FINISH: begin
            if (rsp_free) begin
               post_result = 1'b1;
               state_in    = NPC_IDLE;
            end
         end
         default: state_in = NPC_IDLE;
      endcase
   end

   // Palette memory: load writes, scan reads with registered data
   always_ff @(posedge clock) begin
      if (load_xfer) begin
         palette_mem[req_chan.entry_index[AW-1:0]] <=
            {req_chan.red, req_chan.green, req_chan.blue};
      end
      rd_data_ff <= palette_mem[scan_addr_ff];
   end

   // Pixel latch and scan address counter
   always_ff @(posedge clock) begin
      if (pixel_xfer) begin
         pix_r_ff     <= req_chan.red;
         pix_g_ff     <= req_chan.green;
         pix_b_ff     <= req_chan.blue;
         scan_addr_ff <= AW'(1);
      end else if (issue && scan_addr_ff != LAST_ADDR) begin
         scan_addr_ff <= scan_addr_ff + AW'(1);
      end
   end

   // Stage 1 tags: travel alongside the memory read data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue;
      end
      s1_idx_ff  <= scan_addr_ff;
      s1_last_ff <= (scan_addr_ff == LAST_ADDR);
   end

   // Stage 2: per-channel absolute differences, squares and sum
   always_comb begin
      diff_r   = (pix_r_ff >= rd_data_ff[23:16]) ? pix_r_ff - rd_data_ff[23:16]
                                                 : rd_data_ff[23:16] - pix_r_ff;
      diff_g   = (pix_g_ff >= rd_data_ff[15:8])  ? pix_g_ff - rd_data_ff[15:8]
                                                 : rd_data_ff[15:8] - pix_g_ff;
      diff_b   = (pix_b_ff >= rd_data_ff[7:0])   ? pix_b_ff - rd_data_ff[7:0]
                                                 : rd_data_ff[7:0] - pix_b_ff;
      sq_r     = diff_r * diff_r;
      sq_g     = diff_g * diff_g;
      sq_b     = diff_b * diff_b;
      dist_sum = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_idx_ff  <= s1_idx_ff;
      s2_last_ff <= s1_last_ff;
      dist_ff    <= dist_sum;
   end

   // Stage 3: keep the strictly smaller distance, so the lowest index wins ties
   always_ff @(posedge clock) begin
      if (pixel_xfer) begin
         best_dist_ff <= DIST_START;
         best_idx_ff  <= '0;
      end else if (s2_vld_ff && dist_ff < best_dist_ff) begin
         best_dist_ff <= dist_ff;
         best_idx_ff  <= s2_idx_ff;
      end
   end

   // Output register: holds a result until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (post_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (post_result) begin
         color_ff <= INDEX_W'(best_idx_ff);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.color_index = color_ff;

   // Checks
   `NPC_ASSERT_NEXT(a_pixel_starts_scan, clock, reset, pixel_xfer, state_ff == NPC_SCAN, "pixel accepted but scan did not start")
   `NPC_ASSERT_NOW(a_scan_skips_zero, clock, reset, issue, scan_addr_ff != '0, "scan reads entry zero")
   `NPC_ASSERT_NOW(a_pipe_in_search, clock, reset, s1_vld_ff || s2_vld_ff, state_ff == NPC_SCAN || state_ff == NPC_DRAIN, "pipeline busy outside a search")
   `NPC_ASSERT_NOW(a_result_nonzero, clock, reset, post_result, best_idx_ff != '0, "result would name entry zero")

endmodule

>>> bench/testbench.sv
// Testbench for nearest_palette_color: random palette loads and pixels, checked by a local search.
module testbench
   import npc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES      = DEFAULT_PALETTE_ENTRIES;
   localparam int CHAN_MAX     = (1 << CHAN_W) - 1;
   localparam int RANDOM_ITEMS = 1180;
   localparam int BURST_LOADS  = 48;
   localparam int DRAIN_CYCLES = ENTRIES + 8;
   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int MAX_REPORTS  = 10;

   // Color themes for bursts of palette loads
   typedef enum int {
      STYLE_RANDOM,
      STYLE_FEW,
      STYLE_GRAY
   } palette_style_type;

   // Shadow palette plus the queue of indexes still owed by the block
   class palette_scoreboard_type;
      logic [ENTRY_W-1:0] palette [ENTRIES];
      logic [INDEX_W-1:0] owed_index [$];
      int unsigned        failures;
      int unsigned        result_count;

      function new();
         foreach (palette[i]) palette[i] = '0;
         failures     = 0;
         result_count = 0;
      endfunction

      function logic [2*CHAN_W-1:0] chan_dist(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
         logic [CHAN_W-1:0] d;
         d = (a >= b) ? a - b : b - a;
         return d * d;
      endfunction

      // Least squared RGB distance over entries 1..ENTRIES-1, first one wins a tie
      function logic [INDEX_W-1:0] nearest_index(logic [ENTRY_W-1:0] pixel);
         logic [DIST_W-1:0]  best_dist;
         logic [DIST_W-1:0]  cand_dist;
         logic [INDEX_W-1:0] best;
         best      = '0;
         best_dist = DIST_START;
         for (int i = 1; i < ENTRIES; i++) begin
            cand_dist = chan_dist(pixel[2*CHAN_W +: CHAN_W], palette[i][2*CHAN_W +: CHAN_W])
                      + chan_dist(pixel[CHAN_W +: CHAN_W], palette[i][CHAN_W +: CHAN_W])
                      + chan_dist(pixel[0 +: CHAN_W], palette[i][0 +: CHAN_W]);
            if (cand_dist < best_dist) begin
               best_dist = cand_dist;
               best      = INDEX_W'(i);
            end
         end
         return best;
      endfunction

      function void note_request(logic kind, logic [INDEX_W-1:0] slot,
                                 logic [ENTRY_W-1:0] color);
         if (kind == REQ_LOAD) begin
            if (int'(slot) < ENTRIES) palette[slot] = color;
         end else begin
            owed_index.push_back(nearest_index(color));
         end
      endfunction

      function void report(string what);
         failures++;
         if (failures <= MAX_REPORTS) $display("ERROR: %s", what);
      endfunction

      function void check_color(logic [INDEX_W-1:0] actual);
         logic [INDEX_W-1:0] wanted;
         result_count++;
         if (owed_index.size() == 0) begin
            report($sformatf("result %0d: index %0d arrived with no pixel pending",
                             result_count, actual));
         end else begin
            wanted = owed_index.pop_front();
            if (wanted !== actual)
               report($sformatf("result %0d: color_index expected %0d, actual %0d",
                                result_count, wanted, actual));
         end
      endfunction

      function int pending();
         return owed_index.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        steady_flow;
   int unsigned cycle_count = 0;

   npc_req_if req_chan ();
   npc_rsp_if rsp_chan ();

   nearest_palette_color u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   palette_scoreboard_type sb = new();

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady_flow) return 0;
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   // Random walk of each channel around a base color, clamped
   function automatic logic [ENTRY_W-1:0] nudge(logic [ENTRY_W-1:0] base, int spread);
      logic [ENTRY_W-1:0] out;
      int                 v;
      for (int c = 0; c < 3; c++) begin
         v = int'(base[c*CHAN_W +: CHAN_W]) + int'($urandom_range(0, 2*spread)) - spread;
         if (v < 0) v = 0;
         if (v > CHAN_MAX) v = CHAN_MAX;
         out[c*CHAN_W +: CHAN_W] = CHAN_W'(v);
      end
      return out;
   endfunction

   // One transfer on the request channel, with an optional gap ahead of it
   task automatic send_request(logic kind, logic [INDEX_W-1:0] slot,
                               logic [ENTRY_W-1:0] color);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.req_type    <= kind;
      req_chan.entry_index <= slot;
      req_chan.red         <= color[2*CHAN_W +: CHAN_W];
      req_chan.green       <= color[CHAN_W +: CHAN_W];
      req_chan.blue        <= color[0 +: CHAN_W];
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(kind, slot, color);
   endtask

   // Hold off the sender until every owed index has come back
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Result side: check each transfer, stall at random
   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) sb.check_color(rsp_chan.color_index);
         if (stall_left == 0) stall_left = pick_gap();
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      logic [ENTRY_W-1:0] few_colors [4];
      logic [ENTRY_W-1:0] color;
      logic [INDEX_W-1:0] slot;
      palette_style_type  style;
      int                 items;
      int                 next_burst;
      int                 roll;
      bit                 paused;

      reset                <= 1'b1;
      steady_flow          <= 1'b0;
      req_chan.valid       <= 1'b0;
      req_chan.req_type    <= REQ_LOAD;
      req_chan.entry_index <= '0;
      req_chan.red         <= '0;
      req_chan.green       <= '0;
      req_chan.blue        <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Fill the whole palette before the first search
      for (int i = 0; i < ENTRIES; i++)
         send_request(REQ_LOAD, INDEX_W'(i), ENTRY_W'($urandom()));

      // Entry zero holds an exact match but must never be chosen
      send_request(REQ_LOAD, 8'd0, 24'h123456);
      send_request(REQ_PIXEL, 8'hFF, 24'h123456);
      // Exact match on the first entry
      send_request(REQ_LOAD, 8'd1, 24'h000000);
      send_request(REQ_PIXEL, 8'h00, 24'h000000);
      // Exact match on the last entry
      send_request(REQ_LOAD, 8'd255, 24'hFFFFFF);
      send_request(REQ_PIXEL, 8'hA5, 24'hFFFFFF);
      // Duplicate colors: the lower index wins
      send_request(REQ_LOAD, 8'd7, 24'h808080);
      send_request(REQ_LOAD, 8'd200, 24'h808080);
      send_request(REQ_PIXEL, 8'h5A, 24'h808080);
      // Pixel halfway between two entries
      send_request(REQ_LOAD, 8'd10, 24'h646464);
      send_request(REQ_LOAD, 8'd11, 24'h666464);
      send_request(REQ_PIXEL, 8'h3C, 24'h656464);
      // Primary and mid-scale pixels
      send_request(REQ_PIXEL, 8'h01, 24'hFF0000);
      send_request(REQ_PIXEL, 8'h80, 24'h00FF00);
      send_request(REQ_PIXEL, 8'hC3, 24'h0000FF);
      send_request(REQ_PIXEL, 8'h7E, 24'h7F7F7F);
      drain_results();

      // Random traffic with themed load bursts and one full hold-off
      items      = 0;
      next_burst = 0;
      paused     = 1'b0;
      while (items < RANDOM_ITEMS) begin
         if (items >= next_burst) begin
            steady_flow <= ($urandom_range(0, 3) == 0);
            style = palette_style_type'($urandom_range(0, 2));
            foreach (few_colors[k]) few_colors[k] = ENTRY_W'($urandom());
            for (int k = 0; k < BURST_LOADS; k++) begin
               slot = INDEX_W'($urandom());
               case (style)
                  STYLE_FEW:  color = few_colors[$urandom_range(0, 3)];
                  STYLE_GRAY: color = {3{slot}};
                  default:    color = ENTRY_W'($urandom());
               endcase
               send_request(REQ_LOAD, slot, color);
            end
            items      += BURST_LOADS;
            next_burst = items + 200 + $urandom_range(0, 100);
         end else if (!paused && items >= RANDOM_ITEMS / 2) begin
            drain_results();
            paused = 1'b1;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
               // Single load, sometimes close to an existing entry
               slot  = INDEX_W'($urandom());
               color = (roll < 10) ? nudge(sb.palette[$urandom_range(1, ENTRIES-1)], 3)
                                   : ENTRY_W'($urandom());
               send_request(REQ_LOAD, slot, color);
            end else begin
               // Pixel: exact entry, near an entry, anywhere, or at a cube corner
               if (roll < 55) begin
                  color = sb.palette[$urandom_range(1, ENTRIES-1)];
               end else if (roll < 78) begin
                  color = nudge(sb.palette[$urandom_range(1, ENTRIES-1)], 6);
               end else if (roll < 92) begin
                  color = ENTRY_W'($urandom());
               end else begin
                  for (int c = 0; c < 3; c++)
                     color[c*CHAN_W +: CHAN_W] = $urandom_range(0, 1) ? {CHAN_W{1'b1}}
                                                                     : {CHAN_W{1'b0}};
               end
               send_request(REQ_PIXEL, INDEX_W'($urandom()), color);
            end
            items++;
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
